/* hdl/bba_pkg.sv */
// Shared types and constants for the block bitmap allocator.
// Used by the channel interfaces and by the top level; no dependencies.
`default_nettype none

package bba_pkg;

  localparam int MAX_BLOCKS_DEF    = 16384;
  localparam int MAP_WORD_BITS_DEF = 32;

  localparam int OP_W       = 3;
  localparam int IDX_W      = 14;
  localparam int CNT_W      = 15;
  localparam int ST_W       = 2;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 15;

  localparam logic [OP_W-1:0] OP_INIT  = 3'd0;
  localparam logic [OP_W-1:0] OP_ALLOC = 3'd1;
  localparam logic [OP_W-1:0] OP_FREE  = 3'd2;
  localparam logic [OP_W-1:0] OP_WRITE = 3'd3;
  localparam logic [OP_W-1:0] OP_READ  = 3'd4;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  localparam logic [CFG_ADDR_W-1:0] REG_TOTAL    = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_RESERVED = 2'd1;

  localparam logic [CNT_W-1:0] TOTAL_RESET = 15'd16384;

endpackage

`default_nettype wire

/* hdl/bba_if.sv */
// Valid/ready channel interfaces of the block bitmap allocator:
// operation input, result output and register write port. Uses bba_pkg.
`default_nettype none

interface bba_in_if;
  logic                        valid;
  logic                        ready;
  logic [bba_pkg::OP_W-1:0]    opcode;
  logic [bba_pkg::IDX_W-1:0]   block_index;
  logic                        bit_value;

  modport source (output valid, opcode, block_index, bit_value, input ready);
  modport sink   (input valid, opcode, block_index, bit_value, output ready);
endinterface

interface bba_out_if;
  logic                        valid;
  logic                        ready;
  logic [bba_pkg::IDX_W-1:0]   result_index;
  logic                        read_value;
  logic [bba_pkg::ST_W-1:0]    status;
  logic [bba_pkg::CNT_W-1:0]   free_blocks;

  modport source (output valid, result_index, read_value, status, free_blocks,
                  input ready);
  modport sink   (input valid, result_index, read_value, status, free_blocks,
                  output ready);
endinterface

interface bba_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [bba_pkg::CFG_ADDR_W-1:0]   addr;
  logic [bba_pkg::CFG_DATA_W-1:0]   wdata;

  modport source (output valid, addr, wdata, input ready);
  modport sink   (input valid, addr, wdata, output ready);
endinterface

`default_nettype wire

/* hdl/block_bitmap_allocator.sv */
// Block bitmap allocator, first fit: occupancy map in an on-chip memory
// and a free-block counter. Depends on bba_pkg and the interfaces in bba_if.
//
// Usage:
//   in_chan   one transaction per operation (init, allocate, free, write, read).
//   out_chan  exactly one result transaction per operation, in order.
//   cfg_chan  register writes (0 total_blocks, 1 reserved_blocks); always ready,
//             write only while no operation is in flight.
// Operation, with W = MAX_BLOCKS / word width map words (512 by default):
//   init      all W map words written, one map word per cycle.
//   allocate  up to W words read, one word per cycle through the single
//             read port, lowest clear bit found by a priority encoder.
//   free, write: read, modify, write back; read: read the word, pick the bit.
//   out of range, full count, unknown opcode: straight to the result state.
// One operation at a time; in_chan.ready is high only while idle. A finished
// result sits in the output register, so the next operation is taken while
// the receiver stalls; a second result waits until that register empties.
// Reset: registers take their reset values, then a clearing pass over all W
// map words zeroes the map with in_chan.ready low.
`default_nettype none

module block_bitmap_allocator #(
  parameter int MAX_BLOCKS    = bba_pkg::MAX_BLOCKS_DEF,
  parameter int MAP_WORD_BITS = bba_pkg::MAP_WORD_BITS_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  bba_in_if.sink      in_chan,
  bba_out_if.source   out_chan,
  bba_cfg_if.sink     cfg_chan
);

  localparam int BW        = (MAP_WORD_BITS > 1) ? $clog2(MAP_WORD_BITS) : 1;
  localparam int WB        = 1 << BW;
  localparam int MAP_WORDS = (MAX_BLOCKS + WB - 1) / WB;
  localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int XW        = AW + BW;
  localparam int CW        = (XW + 1 > bba_pkg::CNT_W) ? XW + 1 : bba_pkg::CNT_W;

  localparam logic [CW-1:0] MAX_C     = CW'(MAX_BLOCKS);
  localparam logic [AW:0]   WORDS_C   = (AW + 1)'(MAP_WORDS);
  localparam logic [AW-1:0] LAST_WORD = AW'(MAP_WORDS - 1);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_FILL  = 6'b000010,
    S_SCAN  = 6'b000100,
    S_FETCH = 6'b001000,
    S_MOD   = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  function automatic logic [BW-1:0] lowest_set(input logic [WB-1:0] v);
    logic [BW-1:0] pos;
    pos = '0;
    for (int i = WB - 1; i >= 0; i--) begin
      if (v[i]) pos = BW'(i);
    end
    return pos;
  endfunction

  state_t                       state_r, state_nxt;
  logic [bba_pkg::CNT_W-1:0]    total_r, resv_r;
  logic [bba_pkg::CNT_W-1:0]    free_r, free_nxt;
  logic [bba_pkg::OP_W-1:0]     op_r, op_nxt;
  logic [bba_pkg::IDX_W-1:0]    idx_r, idx_nxt;
  logic                         bit_r, bit_nxt;
  logic [CW-1:0]                fill_lim_r, fill_lim_nxt;
  logic                         fill_reply_r, fill_reply_nxt;
  logic [AW:0]                  ptr_r, ptr_nxt;
  logic [AW-1:0]                chk_w_r, chk_w_nxt;
  logic                         chk_vld_r, chk_vld_nxt;
  logic [WB-1:0]                rdata_r;

  logic [bba_pkg::IDX_W-1:0]    res_idx_r, res_idx_nxt;
  logic                         res_rd_r, res_rd_nxt;
  bba_pkg::status_t             res_st_r, res_st_nxt;

  logic                         out_valid_r;
  logic [bba_pkg::IDX_W-1:0]    out_idx_r;
  logic                         out_rd_r;
  bba_pkg::status_t             out_st_r;
  logic [bba_pkg::CNT_W-1:0]    out_free_r;

  logic [WB-1:0]                map_mem [MAP_WORDS];
  logic                         mem_we;
  logic [AW-1:0]                mem_waddr, mem_raddr;
  logic [WB-1:0]                mem_wdata;

  logic                         accept, out_load;
  logic [CW-1:0]                eff_total, resv_clip, in_idx_c;
  logic [CW-1:0]                ptr_base, fill_diff, found_c, idx_c;
  logic [WB-1:0]                fill_mask, holes, bit_mask;
  logic                         scan_ok, hole_any, found_ok;
  logic [BW-1:0]                hole_pos;

  assign accept          = in_chan.valid && in_chan.ready;
  assign in_chan.ready   = (state_r == S_IDLE);
  assign cfg_chan.ready  = 1'b1;
  assign out_load        = (state_r == S_DONE) && (!out_valid_r || out_chan.ready);

  assign eff_total = (CW'(total_r) > MAX_C) ? MAX_C : CW'(total_r);
  assign resv_clip = (CW'(resv_r) > eff_total) ? eff_total : CW'(resv_r);
  assign in_idx_c  = CW'(in_chan.block_index);
  assign idx_c     = CW'(idx_r);
  assign ptr_base  = CW'({ptr_r[AW-1:0], {BW{1'b0}}});

  // Init pattern for one word: ones below the fill limit.
  assign fill_diff = fill_lim_r - ptr_base;
  always_comb begin
    if (fill_lim_r <= ptr_base) begin
      fill_mask = '0;
    end else if (fill_diff >= CW'(WB)) begin
      fill_mask = '1;
    end else begin
      fill_mask = ~({WB{1'b1}} << fill_diff[BW-1:0]);
    end
  end

  assign scan_ok  = (ptr_r < WORDS_C) && (ptr_base < eff_total);
  assign holes    = ~rdata_r;
  assign hole_any = |holes;
  assign hole_pos = lowest_set(holes);
  assign found_c  = CW'({chk_w_r, hole_pos});
  assign found_ok = found_c < eff_total;
  assign bit_mask = WB'(1) << idx_c[BW-1:0];

  always_comb begin
    state_nxt      = state_r;
    free_nxt       = free_r;
    op_nxt         = op_r;
    idx_nxt        = idx_r;
    bit_nxt        = bit_r;
    fill_lim_nxt   = fill_lim_r;
    fill_reply_nxt = fill_reply_r;
    ptr_nxt        = ptr_r;
    chk_w_nxt      = chk_w_r;
    chk_vld_nxt    = 1'b0;
    res_idx_nxt    = res_idx_r;
    res_rd_nxt     = res_rd_r;
    res_st_nxt     = res_st_r;
    mem_we         = 1'b0;
    mem_waddr      = ptr_r[AW-1:0];
    mem_wdata      = fill_mask;
    mem_raddr      = ptr_r[AW-1:0];

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          op_nxt      = in_chan.opcode;
          idx_nxt     = in_chan.block_index;
          bit_nxt     = in_chan.bit_value;
          res_idx_nxt = '0;
          res_rd_nxt  = 1'b0;
          res_st_nxt  = bba_pkg::ST_OK;
          ptr_nxt     = '0;
          priority if (in_chan.opcode == bba_pkg::OP_INIT) begin
            fill_lim_nxt   = resv_clip;
            fill_reply_nxt = 1'b1;
            free_nxt       = bba_pkg::CNT_W'(eff_total - resv_clip);
            state_nxt      = S_FILL;
          end else if (in_chan.opcode == bba_pkg::OP_ALLOC) begin
            if (free_r == '0) begin
              res_st_nxt = bba_pkg::ST_FULL;
              state_nxt  = S_DONE;
            end else begin
              state_nxt  = S_SCAN;
            end
          end else if (in_chan.opcode == bba_pkg::OP_FREE ||
                       in_chan.opcode == bba_pkg::OP_WRITE ||
                       in_chan.opcode == bba_pkg::OP_READ) begin
            res_idx_nxt = in_chan.block_index;
            if (in_idx_c >= eff_total) begin
              res_st_nxt = bba_pkg::ST_RANGE;
              state_nxt  = S_DONE;
            end else begin
              state_nxt  = S_FETCH;
            end
          end else begin
            state_nxt = S_DONE;
          end
        end
      end

      S_FILL: begin
        mem_we = 1'b1;
        if (ptr_r[AW-1:0] == LAST_WORD) begin
          ptr_nxt   = '0;
          state_nxt = fill_reply_r ? S_DONE : S_IDLE;
        end else begin
          ptr_nxt = ptr_r + 1'b1;
        end
      end

      // Read pointer runs one word ahead of the word being checked.
      S_SCAN: begin
        chk_w_nxt   = ptr_r[AW-1:0];
        chk_vld_nxt = scan_ok;
        if (scan_ok) ptr_nxt = ptr_r + 1'b1;
        if (chk_vld_r && hole_any) begin
          chk_vld_nxt = 1'b0;
          state_nxt   = S_DONE;
          if (found_ok) begin
            mem_we      = 1'b1;
            mem_waddr   = chk_w_r;
            mem_wdata   = rdata_r | (WB'(1) << hole_pos);
            free_nxt    = free_r - 1'b1;
            res_idx_nxt = found_c[bba_pkg::IDX_W-1:0];
          end else begin
            res_st_nxt  = bba_pkg::ST_FULL;
          end
        end else if (!chk_vld_r && !scan_ok) begin
          res_st_nxt = bba_pkg::ST_FULL;
          state_nxt  = S_DONE;
        end
      end

      S_FETCH: begin
        mem_raddr = idx_c[XW-1:BW];
        state_nxt = S_MOD;
      end

      S_MOD: begin
        mem_waddr = idx_c[XW-1:BW];
        state_nxt = S_DONE;
        priority if (op_r == bba_pkg::OP_FREE) begin
          mem_we    = 1'b1;
          mem_wdata = rdata_r & ~bit_mask;
          if (CW'(free_r) < eff_total) free_nxt = free_r + 1'b1;
        end else if (op_r == bba_pkg::OP_WRITE) begin
          mem_we    = 1'b1;
          mem_wdata = bit_r ? (rdata_r | bit_mask) : (rdata_r & ~bit_mask);
        end else begin
          res_rd_nxt = rdata_r[idx_c[BW-1:0]];
        end
      end

      S_DONE: begin
        if (out_load) state_nxt = S_IDLE;
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) map_mem[mem_waddr] <= mem_wdata;
    rdata_r <= map_mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_FILL;
      total_r      <= bba_pkg::TOTAL_RESET;
      resv_r       <= '0;
      free_r       <= bba_pkg::TOTAL_RESET;
      fill_lim_r   <= '0;
      fill_reply_r <= 1'b0;
      ptr_r        <= '0;
      chk_vld_r    <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      free_r       <= free_nxt;
      fill_lim_r   <= fill_lim_nxt;
      fill_reply_r <= fill_reply_nxt;
      ptr_r        <= ptr_nxt;
      chk_vld_r    <= chk_vld_nxt;
      if (cfg_chan.valid) begin
        if (cfg_chan.addr == bba_pkg::REG_TOTAL)    total_r <= cfg_chan.wdata;
        if (cfg_chan.addr == bba_pkg::REG_RESERVED) resv_r  <= cfg_chan.wdata;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    idx_r     <= idx_nxt;
    bit_r     <= bit_nxt;
    chk_w_r   <= chk_w_nxt;
    res_idx_r <= res_idx_nxt;
    res_rd_r  <= res_rd_nxt;
    res_st_r  <= res_st_nxt;
    if (out_load) begin
      out_idx_r  <= res_idx_r;
      out_rd_r   <= res_rd_r;
      out_st_r   <= res_st_r;
      out_free_r <= free_r;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.result_index = out_idx_r;
  assign out_chan.read_value   = out_rd_r;
  assign out_chan.status       = out_st_r;
  assign out_chan.free_blocks  = out_free_r;

`ifndef SYNTH
  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r != S_IDLE))
    else $error("map written while idle");

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_chan.ready)
    else $error("second transaction taken while busy");

  a_full_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.status == bba_pkg::ST_FULL) |->
      (out_chan.result_index == '0 && !out_chan.read_value))
    else $error("failed allocate reports an index");

  a_fill_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FILL && $past(state_r == S_FILL) && $past(rst_n)) |->
      (ptr_r == $past(ptr_r) + 1'b1))
    else $error("fill sweep skipped a word");
`endif

endmodule

`default_nettype wire

/* tb/block_bitmap_allocator_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for block_bitmap_allocator: directed corner cases, then
// randomized phases of init/allocate/free/write/read and unknown-opcode traffic checked against a local predictor.
// Depends on bba_pkg and the channel interfaces in bba_if.

module block_bitmap_allocator_tb;

  localparam logic [bba_pkg::OP_W-1:0] OP_SPARE5 = 3'd5;
  localparam logic [bba_pkg::OP_W-1:0] OP_SPARE6 = 3'd6;
  localparam logic [bba_pkg::OP_W-1:0] OP_SPARE7 = 3'd7;

  typedef struct {
    logic [bba_pkg::IDX_W-1:0] block_idx;
    logic                      read_bit;
    bba_pkg::status_t          status;
    logic [bba_pkg::CNT_W-1:0] free_cnt;
  } alloc_result_t;

  logic clk = 1'b0;
  logic rst_n;

  always #2 clk = ~clk;

  bba_in_if  in_chan ();
  bba_out_if out_chan ();
  bba_cfg_if cfg_chan ();

  block_bitmap_allocator uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  // predictor state
  bit                             occ_bits [bba_pkg::MAX_BLOCKS_DEF];
  logic [bba_pkg::CNT_W-1:0]      free_cnt;
  logic [bba_pkg::CFG_DATA_W-1:0] reg_total;
  logic [bba_pkg::CFG_DATA_W-1:0] reg_reserved;

  alloc_result_t pending_results [$];
  alloc_result_t front_result;
  int mismatch_count = 0;
  int burst_left = 0;
  int random_items = 0;
  int rx_hold = 0;
  logic [9:0] rx_tick = '0;

  function automatic int effective_total();
    return (reg_total > bba_pkg::MAX_BLOCKS_DEF) ? bba_pkg::MAX_BLOCKS_DEF : int'(reg_total);
  endfunction

  function automatic alloc_result_t predict_allocator_op(
      input logic [bba_pkg::OP_W-1:0]  op,
      input logic [bba_pkg::IDX_W-1:0] idx,
      input logic                      val);
    alloc_result_t r;
    int lim;
    int clip;
    int hole;
    lim = effective_total();
    r.block_idx = '0;
    r.read_bit = 1'b0;
    r.status = bba_pkg::ST_OK;
    case (op)
      bba_pkg::OP_INIT: begin
        clip = (reg_reserved > lim) ? lim : int'(reg_reserved);
        for (int i = 0; i < bba_pkg::MAX_BLOCKS_DEF; i++) occ_bits[i] = (i < clip);
        free_cnt = bba_pkg::CNT_W'(lim - clip);
      end
      bba_pkg::OP_ALLOC: begin
        hole = -1;
        // a nonzero count does not guarantee a hole below the total
        if (free_cnt != 0) begin
          for (int i = 0; i < lim && hole < 0; i++) if (!occ_bits[i]) hole = i;
        end
        if (hole < 0) begin
          r.status = bba_pkg::ST_FULL;
        end else begin
          occ_bits[hole] = 1'b1;
          free_cnt = free_cnt - 1'b1;
          r.block_idx = bba_pkg::IDX_W'(hole);
        end
      end
      bba_pkg::OP_FREE, bba_pkg::OP_WRITE, bba_pkg::OP_READ: begin
        r.block_idx = idx;
        if (idx >= lim) begin
          r.status = bba_pkg::ST_RANGE;
        end else if (op == bba_pkg::OP_FREE) begin
          occ_bits[idx] = 1'b0;
          if (free_cnt < lim) free_cnt = free_cnt + 1'b1;
        end else if (op == bba_pkg::OP_WRITE) begin
          occ_bits[idx] = val;
        end else begin
          r.read_bit = occ_bits[idx];
        end
      end
      default: ;
    endcase
    r.free_cnt = free_cnt;
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    mismatch_count++;
    $display("ERROR @%0t: %s", $time, what);
  endtask

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result transaction with nothing pending");
      end else begin
        front_result = pending_results.pop_front();
        if (out_chan.result_index !== front_result.block_idx)
          report_mismatch($sformatf("result_index got %0d want %0d",
                                    out_chan.result_index, front_result.block_idx));
        if (out_chan.read_value !== front_result.read_bit)
          report_mismatch($sformatf("read_value got %b want %b",
                                    out_chan.read_value, front_result.read_bit));
        if (out_chan.status !== front_result.status)
          report_mismatch($sformatf("status got %0d want %s",
                                    out_chan.status, front_result.status.name()));
        if (out_chan.free_blocks !== front_result.free_cnt)
          report_mismatch($sformatf("free_blocks got %0d want %0d",
                                    out_chan.free_blocks, front_result.free_cnt));
      end
    end
  end

  // receiver backpressure: free-running, window-based pattern
  always @(negedge clk) begin
    rx_tick <= rx_tick + 1'b1;
    if (rx_hold != 0) begin
      out_chan.ready <= 1'b0;
      rx_hold <= rx_hold - 1;
    end else begin
      case (rx_tick[9:8])
        2'd0: out_chan.ready <= 1'b1;
        2'd1: out_chan.ready <= ($urandom_range(0, 3) != 0);
        2'd2: begin
          out_chan.ready <= 1'b1;
          if ($urandom_range(0, 5) == 0) rx_hold <= $urandom_range(1, 12);
        end
        default: out_chan.ready <= rx_tick[0];
      endcase
    end
  end

  task automatic send_op(input logic [bba_pkg::OP_W-1:0] op,
                         input logic [bba_pkg::IDX_W-1:0] idx,
                         input logic val);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
      repeat (gap) begin
        @(negedge clk);
        in_chan.valid <= 1'b0;
      end
    end
    burst_left--;
    @(negedge clk);
    in_chan.valid       <= 1'b1;
    in_chan.opcode      <= op;
    in_chan.block_index <= idx;
    in_chan.bit_value   <= val;
    do @(posedge clk); while (!in_chan.ready);
    pending_results.push_back(predict_allocator_op(op, idx, val));
  endtask

  // stop sending and let every outstanding transaction come back
  task automatic drain_results();
    @(negedge clk);
    in_chan.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_reg(input logic [bba_pkg::CFG_ADDR_W-1:0] addr,
                           input logic [bba_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_chan.valid <= 1'b1;
    cfg_chan.addr  <= addr;
    cfg_chan.wdata <= data;
    do @(posedge clk); while (!cfg_chan.ready);
    if (addr == bba_pkg::REG_TOTAL) reg_total = data;
    else if (addr == bba_pkg::REG_RESERVED) reg_reserved = data;
    @(negedge clk);
    cfg_chan.valid <= 1'b0;
  endtask

  task automatic configure(input logic [bba_pkg::CFG_DATA_W-1:0] total,
                           input logic [bba_pkg::CFG_DATA_W-1:0] reserved);
    drain_results();
    write_reg(bba_pkg::REG_TOTAL, total);
    write_reg(bba_pkg::REG_RESERVED, reserved);
  endtask

  function automatic logic [bba_pkg::IDX_W-1:0] pick_index();
    int lim;
    int sel;
    lim = effective_total();
    sel = $urandom_range(0, 9);
    if (lim == 0 || sel == 0) return bba_pkg::IDX_W'($urandom);
    if (sel == 1)
      return bba_pkg::IDX_W'((lim >= bba_pkg::MAX_BLOCKS_DEF) ? lim - 1 : lim);
    return bba_pkg::IDX_W'($urandom_range(0, lim - 1));
  endfunction

  task automatic test_reset_defaults();
    send_op(bba_pkg::OP_READ, 14'h3FFF, 1'b0);
    send_op(bba_pkg::OP_WRITE, 14'h3FFF, 1'b1);
    send_op(bba_pkg::OP_READ, 14'h3FFF, 1'b0);
    send_op(bba_pkg::OP_FREE, 14'h3FFF, 1'b0);   // count already at total, saturates
    send_op(bba_pkg::OP_ALLOC, 14'h0000, 1'b0);
    send_op(bba_pkg::OP_ALLOC, 14'h3FFF, 1'b1);
    send_op(bba_pkg::OP_FREE, 14'h0000, 1'b0);
    send_op(bba_pkg::OP_ALLOC, 14'h0000, 1'b0);
    send_op(bba_pkg::OP_WRITE, 14'h2AAA, 1'b0);
    send_op(OP_SPARE5, 14'h3FFF, 1'b1);
    send_op(OP_SPARE6, 14'h1555, 1'b0);
    send_op(OP_SPARE7, 14'h3FFF, 1'b1);
  endtask

  task automatic test_zero_total();
    configure(15'd0, 15'd0);
    send_op(bba_pkg::OP_ALLOC, 14'h0000, 1'b0);  // count nonzero, but nothing in range
    send_op(bba_pkg::OP_READ, 14'h0000, 1'b0);
    send_op(bba_pkg::OP_INIT, 14'h0000, 1'b0);
  endtask

  task automatic test_reserved_over_total();
    configure(15'd5, 15'd9);
    send_op(bba_pkg::OP_INIT, 14'h0000, 1'b0);
    send_op(bba_pkg::OP_ALLOC, 14'h0000, 1'b0);
    send_op(bba_pkg::OP_READ, 14'd4, 1'b0);
    send_op(bba_pkg::OP_FREE, 14'd5, 1'b0);
  endtask

  // every bit set by writes while the count still claims free blocks
  task automatic test_count_without_hole();
    configure(15'd3, 15'd0);
    send_op(bba_pkg::OP_INIT, 14'h0000, 1'b0);
    send_op(bba_pkg::OP_WRITE, 14'd0, 1'b1);
    send_op(bba_pkg::OP_WRITE, 14'd1, 1'b1);
    send_op(bba_pkg::OP_WRITE, 14'd2, 1'b1);
    send_op(bba_pkg::OP_ALLOC, 14'h0000, 1'b0);
  endtask

  task automatic run_ops(input int n_items);
    int sel;
    logic [bba_pkg::OP_W-1:0] op;
    for (int k = 0; k < n_items; k++) begin
      sel = $urandom_range(0, 99);
      if (sel < 38) op = bba_pkg::OP_ALLOC;
      else if (sel < 60) op = bba_pkg::OP_FREE;
      else if (sel < 74) op = bba_pkg::OP_WRITE;
      else if (sel < 88) op = bba_pkg::OP_READ;
      else if (sel < 92) op = bba_pkg::OP_INIT;
      else op = bba_pkg::OP_W'($urandom_range(5, 7));
      random_items++;
      send_op(op, pick_index(), 1'($urandom));
      if ($urandom_range(0, 59) == 0) drain_results();
    end
  endtask

  task automatic test_random_phases();
    int phase;
    int n;
    logic [bba_pkg::CFG_DATA_W-1:0] t;
    logic [bba_pkg::CFG_DATA_W-1:0] r;
    phase = 0;
    while (random_items < 1090) begin
      if (phase == 0) begin
        t = $urandom_range(100, 300);
        r = '0;
        n = 80;
      end else if (phase == 1 || phase % 16 == 11) begin
        // total above capacity, everything reserved
        t = 15'h7FFF;
        r = 15'h7FFF;
        n = 50;
      end else if (phase % 16 == 3) begin
        // full-size map, only a few free blocks at the top: long scans
        t = 15'd16384;
        r = 15'd16384 - bba_pkg::CFG_DATA_W'($urandom_range(4, 40));
        n = 50;
      end else if (phase % 8 == 6) begin
        t = $urandom_range(1, 4);
        r = $urandom_range(0, 6);
        n = 40;
      end else begin
        t = $urandom_range(1, 300);
        r = ($urandom_range(0, 5) == 0)
              ? t + bba_pkg::CFG_DATA_W'($urandom_range(0, 40))
              : bba_pkg::CFG_DATA_W'($urandom_range(0, t / 2));
        n = $urandom_range(60, 110);
      end
      configure(t, r);
      send_op(bba_pkg::OP_INIT, bba_pkg::IDX_W'($urandom), 1'($urandom));
      random_items++;
      run_ops(n);
      phase++;
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_chan.valid = 1'b0;
    in_chan.opcode = bba_pkg::OP_INIT;
    in_chan.block_index = '0;
    in_chan.bit_value = 1'b0;
    out_chan.ready = 1'b0;
    cfg_chan.valid = 1'b0;
    cfg_chan.addr = bba_pkg::REG_TOTAL;
    cfg_chan.wdata = '0;
    for (int i = 0; i < bba_pkg::MAX_BLOCKS_DEF; i++) occ_bits[i] = 1'b0;
    reg_total = bba_pkg::TOTAL_RESET;
    reg_reserved = '0;
    free_cnt = bba_pkg::TOTAL_RESET;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_zero_total();
    test_reserved_over_total();
    test_count_without_hole();
    test_random_phases();

    drain_results();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("block_bitmap_allocator: match");
    end else begin
      $display("block_bitmap_allocator: mismatch");
    end
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin
    #20_000_000;
    $display("block_bitmap_allocator: mismatch");
    $finish;
  end

endmodule
